@@ design/rpt_pkg.sv @@
// Shared declarations for the rigid point transform.
// Holds the register map of the configuration port; no dependencies.
package rpt_pkg;

    // Register indexes on the configuration port, in address order.
    typedef enum logic [2:0] {
        REG_ROT_X   = 3'd0,
        REG_ROT_Y   = 3'd1,
        REG_ROT_Z   = 3'd2,
        REG_ROT_W   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } reg_idx_t;

    localparam int NUM_REGS = 7;

endpackage

@@ design/rpt_divider.sv @@
// Pipelined restoring divider with round-half-away-from-zero.
// One quotient bit per stage; used by rigid_point_transform; no package needed.
module rpt_divider #(
    parameter int NUM_W = 98,
    parameter int DEN_W = 65,
    parameter int QUO_B = 33
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    out_valid,
    output logic signed [QUO_B:0]   quo
);

    logic                   valid_reg [QUO_B+1];
    logic                   neg_reg   [QUO_B+1];
    logic [NUM_W-1:0]       rem_reg   [QUO_B+1];
    logic [DEN_W-1:0]       den_reg   [QUO_B+1];
    logic [QUO_B-1:0]       q_reg     [QUO_B+1];
    logic [NUM_W-1:0]       rem_next  [QUO_B];
    logic [QUO_B-1:0]       q_next    [QUO_B];
    logic [NUM_W-1:0]       mag_next;
    logic                   out_valid_reg;
    logic signed [QUO_B:0]  quo_reg;
    logic signed [QUO_B:0]  quo_next;
    logic [QUO_B:0]         qr;
    logic                   round_up;

    // Magnitude of the numerator enters the first stage.
    assign mag_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    // Each stage tries the shifted divisor for one quotient bit.
    always_comb
    begin
        for (int i = 0; i < QUO_B; i++)
        begin
            logic [NUM_W-1:0] dsh;
            logic             ge;
            dsh = NUM_W'(den_reg[i]) << (QUO_B - 1 - i);
            ge  = rem_reg[i] >= dsh;
            rem_next[i] = ge ? rem_reg[i] - dsh : rem_reg[i];
            q_next[i]   = {q_reg[i][QUO_B-2:0], ge};
        end
    end

    // Round on the final remainder, then restore the sign.
    assign round_up = {1'b0, rem_reg[QUO_B][DEN_W-1:0], 1'b0} >= (DEN_W+2)'(den_reg[QUO_B]);
    assign qr       = (QUO_B+1)'(q_reg[QUO_B]) + (QUO_B+1)'(round_up);
    assign quo_next = neg_reg[QUO_B] ? -$signed(qr) : $signed(qr);

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QUO_B; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 0; i < QUO_B; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
            out_valid_reg <= valid_reg[QUO_B];
        end
    end

    // Data of the stages.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= mag_next;
        neg_reg[0] <= num[NUM_W-1];
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        for (int i = 0; i < QUO_B; i++)
        begin
            rem_reg[i+1] <= rem_next[i];
            q_reg[i+1]   <= q_next[i];
            neg_reg[i+1] <= neg_reg[i];
            den_reg[i+1] <= den_reg[i];
        end
        quo_reg <= quo_next;
    end

    assign out_valid = out_valid_reg;
    assign quo       = quo_reg;

    // A result leaves only after its operands have passed through every stage.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, QUO_B + 2))
        else $error("divider result without matching operands");

    // The final remainder is always below the divisor.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[QUO_B] |-> (rem_reg[QUO_B] < NUM_W'(den_reg[QUO_B])))
        else $error("divider remainder not reduced");

    // The divisor is never zero.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (den_reg[0] != '0))
        else $error("divider given a zero divisor");

endmodule

@@ design/rigid_point_transform.sv @@
// Top level of the rigid point transform: register file, rotation pipeline, output.
// Depends on rpt_pkg and rpt_divider.
//
//  channel   | signals                                        | direction
//  ----------+------------------------------------------------+----------
//  config    | psel penable pwrite paddr pwdata prdata pready | in / out
//  point     | start busy point_x point_y point_z             | in / out
//  result    | done out_x out_y out_z saturated               | out
//
// One transaction may start in every cycle; busy is always low.
// A point passes through COORD_WIDTH + 10 register stages: six front stages,
// COORD_WIDTH + 3 divider stages (input magnitude, quotient bits and rounding)
// and the output register, from which its result is taken.
// Reset clears the valid bits and loads the identity transform.
// The receiver cannot stall; done marks each result for one cycle.
module rigid_point_transform #(
    parameter int COORD_WIDTH = 32,
    parameter int QUAT_WIDTH  = 32,
    localparam int DATA_W = (COORD_WIDTH > 32 || QUAT_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_W = (DATA_W == 64) ? 6 : 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic                          saturated
);

    import rpt_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int QW      = QUAT_WIDTH;
    localparam int PW      = 2 * QW;
    localparam int MW      = 2 * QW + 2;
    localparam int LW      = QW + 1;
    localparam int HW      = MW - LW;
    localparam int PPW     = LW + 1 + CW;
    localparam int HPW     = HW + CW;
    localparam int EW      = MW + CW;
    localparam int DW      = 2 * QW + 1;
    localparam int QB      = CW + 1;
    localparam int SW      = CW + 3;
    localparam int IDX_LSB = ADDR_W - 3;
    localparam int LATENCY = QB + 9;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    // Configuration registers.
    logic signed [QW-1:0] rot_x_reg, rot_y_reg, rot_z_reg, rot_w_reg;
    logic signed [CW-1:0] shift_reg [3];
    reg_idx_t             idx;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:IDX_LSB]);
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg    <= '0;
            rot_y_reg    <= '0;
            rot_z_reg    <= '0;
            rot_w_reg    <= QW'(1) <<< (QW - 2);
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end
        else if (cfg_wr)
        begin
            case (idx)
                REG_ROT_X:   rot_x_reg    <= pwdata[QW-1:0];
                REG_ROT_Y:   rot_y_reg    <= pwdata[QW-1:0];
                REG_ROT_Z:   rot_z_reg    <= pwdata[QW-1:0];
                REG_ROT_W:   rot_w_reg    <= pwdata[QW-1:0];
                REG_SHIFT_X: shift_reg[0] <= pwdata[CW-1:0];
                REG_SHIFT_Y: shift_reg[1] <= pwdata[CW-1:0];
                REG_SHIFT_Z: shift_reg[2] <= pwdata[CW-1:0];
                default:     ;
            endcase
        end
    end

    // Read-back of the registers.
    always_comb
    begin
        case (idx)
            REG_ROT_X:   prdata = DATA_W'($unsigned(rot_x_reg));
            REG_ROT_Y:   prdata = DATA_W'($unsigned(rot_y_reg));
            REG_ROT_Z:   prdata = DATA_W'($unsigned(rot_z_reg));
            REG_ROT_W:   prdata = DATA_W'($unsigned(rot_w_reg));
            REG_SHIFT_X: prdata = DATA_W'($unsigned(shift_reg[0]));
            REG_SHIFT_Y: prdata = DATA_W'($unsigned(shift_reg[1]));
            REG_SHIFT_Z: prdata = DATA_W'($unsigned(shift_reg[2]));
            default:     prdata = '0;
        endcase
    end

    // A zero quaternion is replaced by the unit scalar, which gives the identity.
    logic                 qzero;
    logic signed [QW-1:0] s_eff;
    assign qzero = (rot_x_reg == '0) && (rot_y_reg == '0) && (rot_z_reg == '0)
                   && (rot_w_reg == '0);
    assign s_eff = qzero ? QW'(1) : rot_w_reg;

    // Pipeline registers.
    logic                  accept;
    logic                  v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [CW-1:0]  p0_reg [3];
    logic signed [CW-1:0]  p1_reg [3];
    logic signed [CW-1:0]  p2_reg [3];
    logic signed [PW-1:0]  pr_reg [10];
    logic signed [PW-1:0]  pr_next [10];
    logic signed [MW-1:0]  m_reg [9];
    logic signed [MW-1:0]  m_next [9];
    logic [DW-1:0]         n2_2_reg, n2_3_reg, n2_4_reg, n2_5_reg;
    logic [DW-1:0]         n2_next;
    logic signed [PPW-1:0] lo_reg [9];
    logic signed [HPW-1:0] hi_reg [9];
    logic signed [EW-1:0]  e_reg [9];
    logic signed [EW-1:0]  n_reg [3];

    assign accept = start && !busy;

    // Quaternion products: ss xx yy zz xy xz yz sx sy sz.
    assign pr_next[0] = s_eff * s_eff;
    assign pr_next[1] = rot_x_reg * rot_x_reg;
    assign pr_next[2] = rot_y_reg * rot_y_reg;
    assign pr_next[3] = rot_z_reg * rot_z_reg;
    assign pr_next[4] = rot_x_reg * rot_y_reg;
    assign pr_next[5] = rot_x_reg * rot_z_reg;
    assign pr_next[6] = rot_y_reg * rot_z_reg;
    assign pr_next[7] = s_eff * rot_x_reg;
    assign pr_next[8] = s_eff * rot_y_reg;
    assign pr_next[9] = s_eff * rot_z_reg;

    // Rotation matrix scaled by the squared length, and the squared length.
    always_comb
    begin
        logic signed [MW-1:0] ss, xx, yy, zz, xy, xz, yz, sx, sy, sz;
        ss = MW'(pr_reg[0]);
        xx = MW'(pr_reg[1]);
        yy = MW'(pr_reg[2]);
        zz = MW'(pr_reg[3]);
        xy = MW'(pr_reg[4]);
        xz = MW'(pr_reg[5]);
        yz = MW'(pr_reg[6]);
        sx = MW'(pr_reg[7]);
        sy = MW'(pr_reg[8]);
        sz = MW'(pr_reg[9]);
        m_next[0] = ss + xx - yy - zz;
        m_next[1] = (xy - sz) <<< 1;
        m_next[2] = (xz + sy) <<< 1;
        m_next[3] = (xy + sz) <<< 1;
        m_next[4] = ss - xx + yy - zz;
        m_next[5] = (yz - sx) <<< 1;
        m_next[6] = (xz - sy) <<< 1;
        m_next[7] = (yz + sx) <<< 1;
        m_next[8] = ss - xx - yy + zz;
        n2_next = DW'($unsigned(pr_reg[0])) + DW'($unsigned(pr_reg[1]))
                  + DW'($unsigned(pr_reg[2])) + DW'($unsigned(pr_reg[3]));
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Datapath of the front stages: products, matrix, partial products, sums.
    always_ff @(posedge clk)
    begin
        p0_reg[0] <= point_x;
        p0_reg[1] <= point_y;
        p0_reg[2] <= point_z;
        for (int j = 0; j < 3; j++)
        begin
            p1_reg[j] <= p0_reg[j];
            p2_reg[j] <= p1_reg[j];
        end
        for (int k = 0; k < 10; k++)
        begin
            pr_reg[k] <= pr_next[k];
        end
        for (int k = 0; k < 9; k++)
        begin
            m_reg[k]  <= m_next[k];
            lo_reg[k] <= $signed({1'b0, m_reg[k][LW-1:0]}) * p2_reg[k % 3];
            hi_reg[k] <= $signed(m_reg[k][MW-1:LW]) * p2_reg[k % 3];
            e_reg[k]  <= (EW'(hi_reg[k]) <<< LW) + EW'(lo_reg[k]);
        end
        for (int i = 0; i < 3; i++)
        begin
            n_reg[i] <= e_reg[3*i] + e_reg[3*i+1] + e_reg[3*i+2];
        end
        n2_2_reg <= n2_next;
        n2_3_reg <= n2_2_reg;
        n2_4_reg <= n2_3_reg;
        n2_5_reg <= n2_4_reg;
    end

    // One divider for each coordinate.
    logic               dv [3];
    logic signed [QB:0] quo [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        rpt_divider #(
            .NUM_W (EW),
            .DEN_W (DW),
            .QUO_B (QB)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v5_reg),
            .num       (n_reg[i]),
            .den       (n2_5_reg),
            .out_valid (dv[i]),
            .quo       (quo[i])
        );
    end

    // Translation, saturation and the output register.
    logic                 done_reg, sat_reg;
    logic signed [CW-1:0] out_reg  [3];
    logic signed [CW-1:0] out_next [3];
    logic [2:0]           clip;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [SW-1:0] sum;
            sum = SW'(quo[i]) + SW'(shift_reg[i]);
            if (sum > SW'(C_MAX))
            begin
                out_next[i] = C_MAX;
                clip[i]     = 1'b1;
            end
            else if (sum < SW'(C_MIN))
            begin
                out_next[i] = C_MIN;
                clip[i]     = 1'b1;
            end
            else
            begin
                out_next[i] = sum[CW-1:0];
                clip[i]     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv[0] && dv[1] && dv[2];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_reg[i] <= out_next[i];
        end
        sat_reg <= |clip;
    end

    assign done      = done_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];
    assign saturated = sat_reg;

    // Every result follows an accepted transaction through the whole pipeline.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching transaction");

    // A clipped result holds a range limit in at least one coordinate.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (out_x == C_MAX || out_x == C_MIN || out_y == C_MAX
            || out_y == C_MIN || out_z == C_MAX || out_z == C_MIN))
        else $error("saturated flag without a clipped coordinate");

    // The squared length never reaches the dividers as zero.
    a_n2_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (n2_2_reg != '0))
        else $error("zero quaternion not replaced");

endmodule
